// ===== rtl/carq_pkg.sv =====
// Shared definitions for the cumulative-ack retransmit queue: command, frame kind and
// configuration register codes, reset values and the retransmit table entry layout.
// No dependencies.
package carq_pkg;

	// Default table depth
	localparam int unsigned SLOTS_DEFAULT = 4;

	// Resends reported per tick at most
	localparam int unsigned MAX_RESENDS = 4;

	// Input commands
	localparam logic [1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [1:0] CMD_HEADER  = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_CMD    = 2'd0;
	localparam logic [1:0] KIND_ACK    = 2'd1;
	localparam logic [1:0] KIND_RESEND = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH  = 3'd4;

	// Configuration reset values
	localparam logic [15:0] TIMEOUT_RESET     = 16'd1800;
	localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd5;
	localparam logic [15:0] MAGIC_RESET       = 16'd0;
	localparam logic [7:0]  VERSION_RESET     = 8'd0;
	localparam logic [9:0]  MIN_LENGTH_RESET  = 10'd16;

	// Retransmit table entry, held in the table RAM
	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] sent_at;
		logic [7:0]  retries;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// One result frame, less its slot number and last flag
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq;
		logic [31:0] ack;
		logic        wants_ack;
		logic        slot_valid;
	} res_t;

endpackage

// ===== rtl/carq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module carq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/cumulative_ack_retransmit_queue.sv =====
// Cumulative-ack retransmit queue: top level. Uses carq_pkg for codes and types and
// carq_ram for the retransmit table.
//
// The block numbers outgoing command frames and keeps up to SLOTS of them in a
// retransmit table until the peer's cumulative ack covers them or a tick drops them
// past the retry limit. It takes one transaction at a time on the request channel.
// An enqueue is accepted, then its command frame goes to the output register. A
// received header and a tick walk the table one slot at a time through the single
// read port of the table RAM, reading each slot and then deciding on it; a resend
// waiting on the response side can hold the walk. A bad header or an unused command
// gives no result. The response channel has an output register, so the walk goes on
// while a frame waits to be taken; the last frame of each transaction carries last.
// Configuration writes land at once and must only come while the block is idle.
module cumulative_ack_retransmit_queue #(
	parameter int unsigned SLOTS = carq_pkg::SLOTS_DEFAULT,
	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_wr_en,
	input  logic [carq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [carq_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [1:0]                       cmd,
	input  logic [9:0]                       rx_length,
	input  logic [15:0]                      rx_magic,
	input  logic [7:0]                       rx_version,
	input  logic [31:0]                      rx_seq,
	input  logic [31:0]                      rx_ack,
	input  logic                             rx_ack_wanted,
	input  logic [31:0]                      now_ms,
	// response channel
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [1:0]                       kind,
	output logic [31:0]                      frame_seq,
	output logic [31:0]                      frame_ack,
	output logic                             wants_ack,
	output logic [SLOT_W-1:0]                slot,
	output logic                             slot_valid,
	output logic                             last
);

	localparam int unsigned RCNT_W = $clog2(carq_pkg::MAX_RESENDS + 1);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_WALK_RD = 5'b00010,
		ST_WALK_EV = 5'b00100,
		ST_FLUSH   = 5'b01000,
		ST_SPARE   = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] timeout_q;
	logic [7:0]  retry_limit_q;
	logic [15:0] magic_q;
	logic [7:0]  version_q;
	logic [9:0]  min_length_q;

	// link state
	logic [31:0]       next_tx_seq_q;
	logic [31:0]       peer_ack_q;
	logic [31:0]       inorder_q;
	logic [SLOTS-1:0]  used_q;

	// walk state
	logic [SLOT_W-1:0] idx_q;
	logic              tick_mode_q;
	logic [31:0]       now_q;
	logic [RCNT_W-1:0] rcnt_q;

	// pending result: held until we know whether it is the last one
	logic              pend_valid_q;
	carq_pkg::res_t    pend_q;
	logic [SLOT_W-1:0] pend_slot_q;

	// output register
	logic              rsp_valid_q;
	carq_pkg::res_t    rsp_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	logic              rsp_last_q;

	// table RAM ports
	logic                           ram_we;
	logic [SLOT_W-1:0]              ram_wr_addr;
	carq_pkg::entry_t               ram_wr_entry;
	logic                           ram_rd_en;
	logic [carq_pkg::ENTRY_W-1:0]   ram_rd_data;
	carq_pkg::entry_t               ent;

	// decode
	logic              accept;
	logic              out_free;
	logic              free_hit;
	logic [SLOT_W-1:0] free_idx;
	logic              hdr_ok;
	logic [31:0]       new_peer;
	logic [31:0]       new_inorder;
	logic              ev_used;
	logic              ev_acked;
	logic              ev_due;
	logic              ev_drop;
	logic              ev_resend;
	logic              ev_free;
	logic              ev_emit;
	logic              ev_block;
	logic              ev_step;
	logic              walk_end;
	logic              out_load;
	logic [7:0]        retries_inc;

	assign accept   = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;

	// lowest free slot
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (!used_q[k]) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(k);
			end
		end
	end

	// header checks and counter updates
	assign hdr_ok = (rx_length >= min_length_q) && (rx_magic == magic_q)
		&& (rx_version == version_q);
	assign new_peer    = (rx_ack > peer_ack_q) ? rx_ack : peer_ack_q;
	assign new_inorder = (rx_seq == inorder_q + 32'd1) ? rx_seq : inorder_q;

	// per-slot decision on the entry just read
	assign ent         = carq_pkg::entry_t'(ram_rd_data);
	assign ev_used     = used_q[idx_q];
	assign ev_acked    = (peer_ack_q >= ent.seq);
	assign ev_due      = (ent.retries == 8'd0) || ((now_q - ent.sent_at) >= {16'd0, timeout_q});
	assign ev_drop     = (ent.retries > retry_limit_q);
	assign ev_resend   = tick_mode_q && ev_used && !ev_acked && ev_due && !ev_drop;
	assign ev_free     = ev_used && (ev_acked || (tick_mode_q && ev_due && ev_drop));
	assign ev_emit     = ev_resend && (rcnt_q < RCNT_W'(carq_pkg::MAX_RESENDS));
	// a second resend must push the held one out first
	assign ev_block    = ev_emit && pend_valid_q && !out_free;
	assign ev_step     = (state_q == ST_WALK_EV) && !ev_block;
	assign walk_end    = (idx_q == SLOT_W'(SLOTS - 1));
	assign retries_inc = (ent.retries == 8'hFF) ? ent.retries : ent.retries + 8'd1;

	assign out_load = pend_valid_q && out_free
		&& (((state_q == ST_WALK_EV) && ev_emit) || (state_q == ST_FLUSH));

	// table writes: allocation on enqueue, resend bookkeeping on tick
	always_comb begin
		ram_we       = 1'b0;
		ram_wr_addr  = idx_q;
		ram_wr_entry = '{seq: ent.seq, sent_at: now_q, retries: retries_inc};
		if (accept && (cmd == carq_pkg::CMD_ENQUEUE) && free_hit) begin
			ram_we       = 1'b1;
			ram_wr_addr  = free_idx;
			ram_wr_entry = '{seq: next_tx_seq_q, sent_at: 32'd0, retries: 8'd0};
		end else if (ev_step && ev_resend) begin
			ram_we = 1'b1;
		end
	end

	assign ram_rd_en = (state_q == ST_WALK_RD);

	carq_ram #(
		.WIDTH (carq_pkg::ENTRY_W),
		.DEPTH (SLOTS)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_entry),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ram_rd_data)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= carq_pkg::TIMEOUT_RESET;
			retry_limit_q <= carq_pkg::RETRY_LIMIT_RESET;
			magic_q       <= carq_pkg::MAGIC_RESET;
			version_q     <= carq_pkg::VERSION_RESET;
			min_length_q  <= carq_pkg::MIN_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				carq_pkg::CFG_TIMEOUT:     timeout_q     <= cfg_data;
				carq_pkg::CFG_RETRY_LIMIT: retry_limit_q <= cfg_data[7:0];
				carq_pkg::CFG_MAGIC:       magic_q       <= cfg_data;
				carq_pkg::CFG_VERSION:     version_q     <= cfg_data[7:0];
				carq_pkg::CFG_MIN_LENGTH:  min_length_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// control and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			next_tx_seq_q <= 32'd1;
			peer_ack_q    <= 32'd0;
			inorder_q     <= 32'd0;
			used_q        <= '0;
			idx_q         <= '0;
			tick_mode_q   <= 1'b0;
			rcnt_q        <= '0;
			pend_valid_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			// drain the output register, refill below
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						rcnt_q <= '0;
						case (cmd)
							carq_pkg::CMD_ENQUEUE: begin
								next_tx_seq_q <= next_tx_seq_q + 32'd1;
								if (free_hit) begin
									used_q[free_idx] <= 1'b1;
								end
								pend_valid_q <= 1'b1;
								state_q      <= ST_FLUSH;
							end
							carq_pkg::CMD_HEADER: begin
								if (hdr_ok) begin
									peer_ack_q   <= new_peer;
									inorder_q    <= new_inorder;
									pend_valid_q <= rx_ack_wanted;
									if (rx_ack_wanted) begin
										next_tx_seq_q <= next_tx_seq_q + 32'd1;
									end
									tick_mode_q <= 1'b0;
									state_q     <= ST_WALK_RD;
								end
							end
							carq_pkg::CMD_TICK: begin
								pend_valid_q <= 1'b0;
								tick_mode_q  <= 1'b1;
								state_q      <= ST_WALK_RD;
							end
							default: ;
						endcase
					end
				end
				ST_WALK_RD: begin
					state_q <= ST_WALK_EV;
				end
				ST_WALK_EV: begin
					if (ev_step) begin
						if (ev_free) begin
							used_q[idx_q] <= 1'b0;
						end
						if (ev_emit) begin
							pend_valid_q <= 1'b1;
							rcnt_q       <= rcnt_q + RCNT_W'(1);
						end
						if (walk_end) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q   <= idx_q + SLOT_W'(1);
							state_q <= ST_WALK_RD;
						end
					end
				end
				ST_FLUSH: begin
					// hold the final frame until the output register frees
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: tick time, pending frame and output register
	always_ff @(posedge clk) begin
		// hold the tick time for the whole walk
		if (accept && (cmd == carq_pkg::CMD_TICK)) begin
			now_q <= now_ms;
		end

		if (accept && (cmd == carq_pkg::CMD_ENQUEUE)) begin
			pend_q      <= '{kind: carq_pkg::KIND_CMD, seq: next_tx_seq_q, ack: inorder_q,
				wants_ack: 1'b1, slot_valid: free_hit};
			pend_slot_q <= free_hit ? free_idx : '0;
		end else if (accept && (cmd == carq_pkg::CMD_HEADER)) begin
			pend_q      <= '{kind: carq_pkg::KIND_ACK, seq: next_tx_seq_q, ack: new_inorder,
				wants_ack: 1'b0, slot_valid: 1'b0};
			pend_slot_q <= '0;
		end else if (ev_step && ev_emit) begin
			pend_q      <= '{kind: carq_pkg::KIND_RESEND, seq: ent.seq, ack: 32'd0,
				wants_ack: 1'b1, slot_valid: 1'b1};
			pend_slot_q <= idx_q;
		end

		if (out_load) begin
			rsp_q      <= pend_q;
			rsp_slot_q <= pend_slot_q;
			rsp_last_q <= (state_q == ST_FLUSH);
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign kind       = rsp_q.kind;
	assign frame_seq  = rsp_q.seq;
	assign frame_ack  = rsp_q.ack;
	assign wants_ack  = rsp_q.wants_ack;
	assign slot       = rsp_slot_q;
	assign slot_valid = rsp_q.slot_valid;
	assign last       = rsp_last_q;

endmodule

// ===== dv/carq_tb_pkg.sv =====
`timescale 1ns / 100ps
// Transaction types and the scoreboard for the retransmit queue testbench.
// Depends on carq_pkg for command, frame kind and register codes.
package carq_tb_pkg;
	import carq_pkg::*;

	localparam int unsigned TB_SLOTS = SLOTS_DEFAULT;

	typedef struct {
		logic [1:0]  cmd;
		logic [9:0]  rx_length;
		logic [15:0] rx_magic;
		logic [7:0]  rx_version;
		logic [31:0] rx_seq;
		logic [31:0] rx_ack;
		logic        rx_ack_wanted;
		logic [31:0] now_ms;
	} request_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] frame_seq;
		logic [31:0] frame_ack;
		logic        wants_ack;
		logic [1:0]  slot;
		logic        slot_valid;
		logic        last;
	} frame_t;

	class retx_scoreboard;
		logic [15:0] timeout_ms;
		logic [7:0]  retry_limit;
		logic [15:0] expected_magic;
		logic [7:0]  expected_version;
		logic [9:0]  min_header_length;

		logic [31:0] next_tx_seq;
		logic [31:0] peer_ack;
		logic [31:0] inorder_rx_seq;
		bit          slot_used [TB_SLOTS];
		logic [31:0] slot_seq [TB_SLOTS];
		logic [31:0] slot_sent_at [TB_SLOTS];
		logic [7:0]  slot_retries [TB_SLOTS];

		frame_t      expected_frames [$];

		int unsigned errors, frames_checked;
		int unsigned n_requests, n_enqueues, n_full, n_headers, n_ticks, n_resends, n_drops;

		function new();
			timeout_ms = TIMEOUT_RESET;
			retry_limit = RETRY_LIMIT_RESET;
			expected_magic = MAGIC_RESET;
			expected_version = VERSION_RESET;
			min_header_length = MIN_LENGTH_RESET;
			next_tx_seq = 32'd1;
			peer_ack = '0;
			inorder_rx_seq = '0;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
			CFG_TIMEOUT:     timeout_ms = data;
			CFG_RETRY_LIMIT: retry_limit = data[7:0];
			CFG_MAGIC:       expected_magic = data;
			CFG_VERSION:     expected_version = data[7:0];
			CFG_MIN_LENGTH:  min_header_length = data[9:0];
			default: ;
			endcase
		endfunction

		// Apply one accepted request and queue the frames it must produce.
		function void predict_request(request_t r);
			frame_t      fresh [$];
			frame_t      f;
			int          free_slot;
			logic [31:0] seq;
			n_requests++;
			case (r.cmd)
			CMD_ENQUEUE: begin
				n_enqueues++;
				seq = next_tx_seq;
				next_tx_seq = seq + 32'd1;
				free_slot = -1;
				for (int i = 0; i < TB_SLOTS; i++)
					if (!slot_used[i] && free_slot < 0) free_slot = i;
				f = '{KIND_CMD, seq, inorder_rx_seq, 1'b1, 2'd0, 1'b0, 1'b0};
				if (free_slot >= 0) begin
					slot_used[free_slot] = 1'b1;
					slot_seq[free_slot] = seq;
					slot_sent_at[free_slot] = '0;
					slot_retries[free_slot] = '0;
					f.slot = 2'(free_slot);
					f.slot_valid = 1'b1;
				end else begin
					n_full++;
				end
				fresh.push_back(f);
			end
			CMD_HEADER: begin
				if (r.rx_length >= min_header_length && r.rx_magic == expected_magic &&
				    r.rx_version == expected_version) begin
					n_headers++;
					if (r.rx_ack > peer_ack) peer_ack = r.rx_ack;
					for (int i = 0; i < TB_SLOTS; i++)
						if (slot_used[i] && slot_seq[i] <= peer_ack) slot_used[i] = 1'b0;
					if (r.rx_seq == inorder_rx_seq + 32'd1) inorder_rx_seq = r.rx_seq;
					if (r.rx_ack_wanted) begin
						seq = next_tx_seq;
						next_tx_seq = seq + 32'd1;
						fresh.push_back('{KIND_ACK, seq, inorder_rx_seq, 1'b0, 2'd0, 1'b0, 1'b0});
					end
				end
			end
			CMD_TICK: begin
				n_ticks++;
				for (int i = 0; i < TB_SLOTS; i++) begin
					if (!slot_used[i]) continue;
					if (peer_ack >= slot_seq[i]) begin
						slot_used[i] = 1'b0;
						continue;
					end
					if (slot_retries[i] == 8'd0 || (r.now_ms - slot_sent_at[i]) >= {16'd0, timeout_ms}) begin
						if (slot_retries[i] > retry_limit) begin
							slot_used[i] = 1'b0;
							n_drops++;
							continue;
						end
						if (fresh.size() < MAX_RESENDS)
							fresh.push_back('{KIND_RESEND, slot_seq[i], 32'd0, 1'b1, 2'(i), 1'b1, 1'b0});
						n_resends++;
						slot_sent_at[i] = r.now_ms;
						if (slot_retries[i] != 8'hFF) slot_retries[i]++;
					end
				end
			end
			default: ;
			endcase
			if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
			foreach (fresh[k]) expected_frames.push_back(fresh[k]);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_frame(frame_t got);
			frame_t want;
			frames_checked++;
			if (expected_frames.size() == 0) begin
				$error("frame with nothing pending: kind %0d seq 0x%0h", got.kind, got.frame_seq);
				errors++;
				return;
			end
			want = expected_frames.pop_front();
			compare_field("kind", 32'(want.kind), 32'(got.kind));
			compare_field("frame_seq", want.frame_seq, got.frame_seq);
			compare_field("frame_ack", want.frame_ack, got.frame_ack);
			compare_field("wants_ack", 32'(want.wants_ack), 32'(got.wants_ack));
			compare_field("slot", 32'(want.slot), 32'(got.slot));
			compare_field("slot_valid", 32'(want.slot_valid), 32'(got.slot_valid));
			compare_field("last", 32'(want.last), 32'(got.last));
		endfunction

		function void report_leftovers();
			if (expected_frames.size() != 0) begin
				$error("%0d expected frames never arrived", expected_frames.size());
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== dv/tb_cumulative_ack_retransmit_queue.sv =====
`timescale 1ns / 100ps
// Testbench for cumulative_ack_retransmit_queue: directed and random transactions
// checked frame by frame against a scoreboard. Depends on carq_pkg and carq_tb_pkg.
module tb_cumulative_ack_retransmit_queue;
	import carq_pkg::*;
	import carq_tb_pkg::*;

	// Command code the block does not decode, and a register index it does not map
	localparam logic [1:0]           CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 3'd7;

	// Quiet cycles after the last frame: covers a full table walk with margin
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES   = 150;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	logic [1:0]            cmd;
	logic [9:0]            rx_length;
	logic [15:0]           rx_magic;
	logic [7:0]            rx_version;
	logic [31:0]           rx_seq;
	logic [31:0]           rx_ack;
	logic                  rx_ack_wanted;
	logic [31:0]           now_ms;
	logic                  rsp_valid;
	logic                  rsp_stall;
	logic [1:0]            kind;
	logic [31:0]           frame_seq;
	logic [31:0]           frame_ack;
	logic                  wants_ack;
	logic [1:0]            slot;
	logic                  slot_valid;
	logic                  last;

	retx_scoreboard sb;

	// Idle chances in percent per cycle slot, and a request for a long output hold
	int unsigned send_idle_pct;
	int unsigned rsp_idle_pct;
	int unsigned rsp_hold_req;

	// Millisecond clock that tick transactions carry
	logic [31:0] clock_ms;

	cumulative_ack_retransmit_queue #(.SLOTS(TB_SLOTS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.cmd           (cmd),
		.rx_length     (rx_length),
		.rx_magic      (rx_magic),
		.rx_version    (rx_version),
		.rx_seq        (rx_seq),
		.rx_ack        (rx_ack),
		.rx_ack_wanted (rx_ack_wanted),
		.now_ms        (now_ms),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.kind          (kind),
		.frame_seq     (frame_seq),
		.frame_ack     (frame_ack),
		.wants_ack     (wants_ack),
		.slot          (slot),
		.slot_valid    (slot_valid),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Output side: drive stall at the falling edge. A long hold, once requested, is
	// counted here; otherwise stall in random bursts.
	initial begin : rsp_side
		int unsigned burst;
		int unsigned hold;
		burst = 0;
		hold = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_req != 0) begin
				hold = rsp_hold_req;
				rsp_hold_req = 0;
			end
			if (hold != 0) begin
				rsp_stall = 1'b1;
				hold--;
			end else if (burst != 0) begin
				rsp_stall = 1'b1;
				burst--;
			end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
				rsp_stall = 1'b1;
				burst = $urandom_range(0, 3);
			end else begin
				rsp_stall = 1'b0;
			end
		end
	end

	// Sample every completed output transaction at the rising edge
	always @(posedge clk) begin : frame_monitor
		frame_t seen;
		if (arst_n && rsp_valid && !rsp_stall) begin
			seen = '{kind, frame_seq, frame_ack, wants_ack, slot, slot_valid, last};
			sb.check_frame(seen);
		end
	end

	// Offer one transaction, starting at a falling edge. Hold the payload until the
	// block takes it, then either keep valid high for the next one or idle a burst.
	task automatic send_request(input request_t r);
		req_valid = 1'b1;
		cmd = r.cmd;
		rx_length = r.rx_length;
		rx_magic = r.rx_magic;
		rx_version = r.rx_version;
		rx_seq = r.rx_seq;
		rx_ack = r.rx_ack;
		rx_ack_wanted = r.rx_ack_wanted;
		now_ms = r.now_ms;
		do @(posedge clk); while (req_stall);
		sb.predict_request(r);
		@(negedge clk);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every expected frame is in, then let the block settle
	task automatic wait_idle();
		req_valid = 1'b0;
		while (sb.expected_frames.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
	                         input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.write_reg(index, data);
	endtask

	// Random content in every field; callers override what matters
	function automatic request_t noise_request(logic [1:0] op);
		request_t r;
		r.cmd = op;
		r.rx_length = 10'($urandom);
		r.rx_magic = 16'($urandom);
		r.rx_version = 8'($urandom);
		r.rx_seq = $urandom;
		r.rx_ack = $urandom;
		r.rx_ack_wanted = 1'($urandom);
		r.now_ms = $urandom;
		return r;
	endfunction

	// Header that passes the checks. Mostly in-order sequence numbers and acks that
	// free the oldest frames; hold_acks never raises the peer ack, wild_acks allows
	// any 32-bit ack.
	function automatic request_t good_header(bit hold_acks, bit wild_acks);
		request_t    r;
		logic [31:0] sent_top;
		r = noise_request(CMD_HEADER);
		sent_top = sb.next_tx_seq - 32'd1;
		r.rx_length = 10'($urandom_range(sb.min_header_length, 1023));
		r.rx_magic = sb.expected_magic;
		r.rx_version = sb.expected_version;
		if ($urandom_range(0, 2) != 0)
			r.rx_seq = sb.inorder_rx_seq + 32'd1;
		else if ($urandom_range(0, 1) != 0)
			r.rx_seq = sb.inorder_rx_seq + 32'd2;
		case ($urandom_range(0, 9))
		0, 1, 2, 3: r.rx_ack = sb.peer_ack >> $urandom_range(0, 1);
		4, 5, 6, 7: begin
			r.rx_ack = sb.peer_ack + $urandom_range(1, 2);
			if (r.rx_ack > sent_top) r.rx_ack = sent_top;
		end
		8: r.rx_ack = sent_top;
		default: r.rx_ack = wild_acks ? $urandom : sb.peer_ack;
		endcase
		if (hold_acks && r.rx_ack > sb.peer_ack) r.rx_ack = sb.peer_ack;
		return r;
	endfunction

	// Header that fails exactly one of the length, magic and version checks
	function automatic request_t bad_header();
		request_t r;
		r = noise_request(CMD_HEADER);
		r.rx_length = 10'($urandom_range(sb.min_header_length, 1023));
		r.rx_magic = sb.expected_magic;
		r.rx_version = sb.expected_version;
		case ($urandom_range(0, 2))
		0: begin
			if (sb.min_header_length != 0)
				r.rx_length = 10'($urandom_range(0, sb.min_header_length - 1));
			else
				r.rx_magic = ~sb.expected_magic;
		end
		1: r.rx_magic = sb.expected_magic ^ 16'(1 << $urandom_range(0, 15));
		default: r.rx_version = sb.expected_version ^ 8'($urandom_range(1, 255));
		endcase
		return r;
	endfunction

	// Advance the millisecond clock: repeats, short steps, the timeout boundary,
	// past it, and the odd wild jump. steady always lands at or past the timeout.
	function automatic logic [31:0] tick_step(bit steady);
		logic [31:0] t;
		t = {16'd0, sb.timeout_ms};
		if (steady) return t + $urandom_range(0, t);
		case ($urandom_range(0, 9))
		0: return 32'd0;
		1, 2, 3: return $urandom_range(1, t / 2 + 1);
		4, 5: return t;
		6: return t - 32'd1;
		7, 8: return t + $urandom_range(0, t);
		default: return $urandom;
		endcase
	endfunction

	task automatic send_enqueue();
		send_request(noise_request(CMD_ENQUEUE));
	endtask

	task automatic send_tick(input logic [31:0] at_ms);
		request_t r;
		r = noise_request(CMD_TICK);
		r.now_ms = at_ms;
		send_request(r);
	endtask

	task automatic send_header(input logic [9:0] len, input logic [15:0] magic,
	                           input logic [7:0] ver, input logic [31:0] seq,
	                           input logic [31:0] ack, input logic want);
		request_t r;
		r = noise_request(CMD_HEADER);
		r.rx_length = len;
		r.rx_magic = magic;
		r.rx_version = ver;
		r.rx_seq = seq;
		r.rx_ack = ack;
		r.rx_ack_wanted = want;
		send_request(r);
	endtask

	// Random phase. Weights are percent; ticks take what is left but for a sliver of
	// undecoded commands. Idling switches off for every third run of 32 transactions.
	task automatic run_phase(input int unsigned count, input int unsigned enq_w,
	                         input int unsigned hdr_w, input int unsigned bad_w,
	                         input bit steady, input bit hold_acks, input bit wild_acks,
	                         input bit idle_on, input int hold_at);
		request_t    r;
		int unsigned pick;
		bit          idling;
		for (int k = 0; k < count; k++) begin
			idling = idle_on && ((k / 32) % 3 != 2);
			send_idle_pct = idling ? 25 : 0;
			rsp_idle_pct = idling ? 30 : 0;
			if (k == hold_at) rsp_hold_req = HOLD_CYCLES;
			pick = $urandom_range(0, 99);
			if (pick < enq_w) begin
				r = noise_request(CMD_ENQUEUE);
			end else if (pick < enq_w + hdr_w) begin
				r = good_header(hold_acks, wild_acks);
			end else if (pick < enq_w + hdr_w + bad_w) begin
				r = bad_header();
			end else if (pick < 98) begin
				r = noise_request(CMD_TICK);
				clock_ms = clock_ms + tick_step(steady);
				r.now_ms = clock_ms;
			end else begin
				r = noise_request(CMD_UNUSED);
			end
			send_request(r);
		end
	endtask

	initial begin : stimulus
		request_t r;
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_TIMEOUT;
		cfg_data = '0;
		req_valid = 1'b0;
		cmd = CMD_ENQUEUE;
		rx_length = '0;
		rx_magic = '0;
		rx_version = '0;
		rx_seq = '0;
		rx_ack = '0;
		rx_ack_wanted = 1'b0;
		now_ms = '0;
		send_idle_pct = 20;
		rsp_idle_pct = 20;
		rsp_hold_req = 0;
		clock_ms = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pass at reset configuration. Tick with an empty table, then an
		// undecoded command with every field set.
		send_tick(32'd0);
		r = noise_request(CMD_UNUSED);
		r.rx_length = '1;
		r.rx_magic = '1;
		r.rx_version = '1;
		r.rx_seq = '1;
		r.rx_ack = '1;
		r.rx_ack_wanted = 1'b1;
		r.now_ms = '1;
		send_request(r);
		// Fill all four slots, then one more against a full table
		repeat (5) send_enqueue();
		// First resend regardless of time, then just short of and exactly at timeout
		send_tick(32'd0);
		send_tick(32'd1799);
		send_tick(32'd1800);
		// Short, wrong magic, wrong version: all ignored even with an ack wanted
		send_header(10'd15, 16'h0000, 8'h00, 32'd1, 32'd2, 1'b1);
		send_header(10'd16, 16'h0001, 8'h00, 32'd1, 32'd2, 1'b1);
		send_header(10'd16, 16'h0000, 8'h80, 32'd1, 32'd2, 1'b1);
		// Ack covering the two oldest; in-order receive; ack frame back
		send_header(10'd16, 16'h0000, 8'h00, 32'd1, 32'd2, 1'b1);
		// Out-of-order receive and a lower ack that must not pull the peer ack back
		send_header(10'h3FF, 16'h0000, 8'h00, 32'd3, 32'd1, 1'b1);
		send_header(10'h3FF, 16'h0000, 8'h00, 32'd2, 32'd0, 1'b0);
		// Lowest free slot is reused
		send_enqueue();
		// Elapsed time across the 32-bit wrap, then drive retries past the limit
		send_tick(32'hFFFF_FFFF);
		send_tick(32'h0000_0100);
		send_tick(32'h0000_0707);
		send_tick(32'h0000_0E0F);
		send_tick(32'h0000_1517);
		send_tick(32'h0000_1C1F);
		send_header(10'd16, 16'h0000, 8'h00, 32'd0, 32'd0, 1'b1);
		send_enqueue();
		wait_idle();

		// Moderate timeout, random identity; hold the output a long stretch midway so
		// the block backs up into its input
		write_reg(CFG_TIMEOUT, 16'($urandom_range(50, 400)));
		write_reg(CFG_RETRY_LIMIT, 16'd3);
		write_reg(CFG_MAGIC, 16'($urandom));
		write_reg(CFG_VERSION, 16'($urandom_range(0, 255)));
		write_reg(CFG_MIN_LENGTH, 16'($urandom_range(0, 64)));
		clock_ms = $urandom;
		run_phase(50, 30, 28, 10, 1'b0, 1'b0, 1'b0, 1'b1, 16);
		wait_idle();

		// Top values of timeout, magic and version, no retries, time starting just below the wrap
		write_reg(CFG_SPARE, 16'($urandom));
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		write_reg(CFG_RETRY_LIMIT, 16'd0);
		write_reg(CFG_MAGIC, 16'hFFFF);
		write_reg(CFG_VERSION, 16'h00FF);
		write_reg(CFG_MIN_LENGTH, 16'd0);
		clock_ms = 32'hFFFF_0000;
		run_phase(40, 30, 28, 10, 1'b0, 1'b0, 1'b0, 1'b1, -1);
		wait_idle();

		// Shortest timeout, no retry drop, headers never advance the ack: keep the
		// table full and resend every tick until the retry count saturates. Upper
		// data bits of the narrow registers are don't-care.
		write_reg(CFG_TIMEOUT, 16'd1);
		write_reg(CFG_RETRY_LIMIT, 16'hA5FF);
		write_reg(CFG_MAGIC, 16'h0000);
		write_reg(CFG_VERSION, 16'h5A00);
		write_reg(CFG_MIN_LENGTH, 16'hFFFF);
		repeat (TB_SLOTS) send_enqueue();
		run_phase(310, 3, 3, 2, 1'b1, 1'b1, 1'b0, 1'b1, -1);
		wait_idle();

		// Limit just under saturation drops the saturated entries; no idling from here
		write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 3000)));
		write_reg(CFG_RETRY_LIMIT, 16'd254);
		write_reg(CFG_MAGIC, 16'($urandom));
		write_reg(CFG_VERSION, 16'($urandom_range(0, 255)));
		write_reg(CFG_MIN_LENGTH, 16'($urandom_range(0, 1023)));
		run_phase(30, 25, 30, 10, 1'b0, 1'b0, 1'b1, 1'b0, -1);
		// Ack of all ones covers every frame from now on
		send_header(10'h3FF, sb.expected_magic, sb.expected_version, '1, '1, 1'b1);
		send_tick(clock_ms);
		send_enqueue();
		send_tick(clock_ms + {16'd0, sb.timeout_ms});
		wait_idle();

		sb.report_leftovers();
		$display("Covered %0d transactions: %0d enqueues (%0d on a full table), %0d good headers,",
		         sb.n_requests, sb.n_enqueues, sb.n_full, sb.n_headers);
		$display("%0d ticks with %0d resends and %0d retry drops; %0d frames checked.",
		         sb.n_ticks, sb.n_resends, sb.n_drops, sb.frames_checked);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
